// ===== src/bdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants for the push-button qualifier: item function
// codes, configuration register indexes, reset values and the state record.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    // Field and register widths.
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned HIST_W   = 8;
    localparam int unsigned HOLD_W   = 16;
    localparam int unsigned RPT_W    = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Default width of the stability window, in samples (1 to 8).
    localparam int unsigned STABLE_SAMPLES_DEF = 4;

    // Item function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_READ     = 2'd1,
        FUNC_READ_CLR = 2'd2
    } t_func;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_ENABLE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_HALF_PERIOD = 3'd4;

    // Configuration reset values.
    localparam logic [HOLD_W-1:0] LONG_PRESS_TICKS_RST   = 16'd100;
    localparam logic [HOLD_W-1:0] REPEAT_START_TICKS_RST = 16'd50;
    localparam logic [RPT_W-1:0]  REPEAT_HALF_PERIOD_RST = 15'd10;

    // Configuration as seen by the update logic.
    typedef struct packed {
        logic              long_press_enable;
        logic              repeat_enable;
        logic [HOLD_W-1:0] long_press_ticks;
        logic [HOLD_W-1:0] repeat_start_ticks;
        logic [RPT_W-1:0]  repeat_half_period;
    } t_cfg;

    // Key qualifier state.
    typedef struct packed {
        logic [HIST_W-1:0] history;
        logic              debounced;
        logic              reported;
        logic [HOLD_W-1:0] hold_count;
        logic [RPT_W-1:0]  repeat_count;
        logic              pulse_on_release;
        logic              pulse_pending;
        logic              long_press_seen;
    } t_state;

    // One result item.
    typedef struct packed {
        logic changed;
        logic reported;
        logic long_hold;
    } t_result;

endpackage

// ===== src/button_debounce_long_press_repeat_unit.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_unit
// Single-key push-button qualifier with debouncing, auto-repeat and
// long-press detection.
// ----------------------------------------------------------------------------
// Each item (a tick carrying a raw sample, or a read) is applied to the key
// state in the clock cycle of its transfer, and its result is held in an
// output register until taken. One item is accepted per cycle, and its result
// is shown in the cycle after; the only limit is the output register, which
// frees itself in the same cycle its result is transferred. Configuration
// writes take effect at once and are meant to be made while no result is outstanding.
module button_debounce_long_press_repeat_unit #(
    parameter int unsigned STABLE_SAMPLES = bdlp_pkg::STABLE_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Item input
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bdlp_pkg::FUNC_W-1:0]     i_func,
    input  logic                            i_sample,
    // Result output
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_changed,
    output logic                            o_reported,
    output logic                            o_long_hold,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [bdlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bdlp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    bdlp_pkg::t_cfg    r_cfg;
    bdlp_pkg::t_state  r_state;
    bdlp_pkg::t_state  n_state;
    bdlp_pkg::t_result r_result;
    bdlp_pkg::t_result n_result;
    logic              r_out_valid;
    logic              in_xfer;

    // Accept whenever the output register is empty or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_enable  <= 1'b0;
            r_cfg.repeat_enable      <= 1'b0;
            r_cfg.long_press_ticks   <= bdlp_pkg::LONG_PRESS_TICKS_RST;
            r_cfg.repeat_start_ticks <= bdlp_pkg::REPEAT_START_TICKS_RST;
            r_cfg.repeat_half_period <= bdlp_pkg::REPEAT_HALF_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bdlp_pkg::CFG_LONG_PRESS_ENABLE:  r_cfg.long_press_enable  <= i_cfg_data[0];
                bdlp_pkg::CFG_REPEAT_ENABLE:      r_cfg.repeat_enable      <= i_cfg_data[0];
                bdlp_pkg::CFG_LONG_PRESS_TICKS:   r_cfg.long_press_ticks   <= i_cfg_data;
                bdlp_pkg::CFG_REPEAT_START_TICKS: r_cfg.repeat_start_ticks <= i_cfg_data;
                bdlp_pkg::CFG_REPEAT_HALF_PERIOD: begin
                    r_cfg.repeat_half_period <= i_cfg_data[bdlp_pkg::RPT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Per-item update logic.
    bdlp_step #(
        .STABLE_SAMPLES (STABLE_SAMPLES)
    ) u_step (
        .i_func   (i_func),
        .i_sample (i_sample),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Key state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_xfer) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_changed   = r_result.changed;
    assign o_reported  = r_result.reported;
    assign o_long_hold = r_result.long_hold;

endmodule

// ===== src/bdlp_step.sv =====
// ----------------------------------------------------------------------------
// bdlp_step
// Next-state and result logic for one item: shifts the sample into the
// history window, qualifies the level and runs the repeat and long-press rules.
// ----------------------------------------------------------------------------
module bdlp_step #(
    parameter int unsigned STABLE_SAMPLES = bdlp_pkg::STABLE_SAMPLES_DEF
) (
    input  logic [bdlp_pkg::FUNC_W-1:0] i_func,
    input  logic                        i_sample,
    input  bdlp_pkg::t_cfg              i_cfg,
    input  bdlp_pkg::t_state            i_state,
    output bdlp_pkg::t_state            o_state,
    output bdlp_pkg::t_result           o_result
);

    localparam logic [bdlp_pkg::HOLD_W-1:0] HOLD_MAX = '1;
    localparam logic [bdlp_pkg::HOLD_W-1:0] HOLD_ONE = {{(bdlp_pkg::HOLD_W-1){1'b0}}, 1'b1};
    localparam logic [bdlp_pkg::RPT_W-1:0]  RPT_ONE  = {{(bdlp_pkg::RPT_W-1){1'b0}}, 1'b1};

    logic [bdlp_pkg::HIST_W-1:0]     hist_next;
    logic [STABLE_SAMPLES-1:0]       win;
    logic [bdlp_pkg::HOLD_W-1:0]     hold_inc;
    logic [bdlp_pkg::RPT_W-1:0]      rpt_dec;
    logic                            changed;
    bdlp_pkg::t_state                n_st;

    // Shifted history and the newest window of samples.
    assign hist_next = {i_state.history[bdlp_pkg::HIST_W-2:0], i_sample};
    assign win       = hist_next[STABLE_SAMPLES-1:0];
    assign hold_inc  = (i_state.hold_count == HOLD_MAX) ? HOLD_MAX
                                                        : i_state.hold_count + HOLD_ONE;
    assign rpt_dec   = i_state.repeat_count - RPT_ONE;

    // Item update.
    always_comb begin
        n_st    = i_state;
        changed = 1'b0;
        unique case (bdlp_pkg::t_func'(i_func))
            bdlp_pkg::FUNC_TICK: begin
                n_st.history = hist_next;
                if (&win) begin
                    if (!i_state.debounced) begin
                        // Fresh press: shown at once, or held back in long-press mode.
                        n_st.debounced = 1'b1;
                        if (i_cfg.long_press_enable) begin
                            n_st.pulse_on_release = 1'b1;
                            n_st.reported         = 1'b0;
                        end else begin
                            n_st.reported = 1'b1;
                            changed       = 1'b1;
                        end
                    end else if (i_state.repeat_count == RPT_ONE
                                 && !i_cfg.long_press_enable) begin
                        // Repeat interval has run out: toggle and reload.
                        n_st.reported     = ~i_state.reported;
                        n_st.repeat_count = i_cfg.repeat_half_period;
                        changed           = 1'b1;
                    end else begin
                        if (i_state.repeat_count != '0 && !i_cfg.long_press_enable) begin
                            n_st.repeat_count = rpt_dec;
                        end
                        n_st.hold_count = hold_inc;
                        if (i_state.pulse_on_release) begin
                            if (hold_inc >= i_cfg.long_press_ticks) begin
                                n_st.pulse_on_release = 1'b0;
                                n_st.long_press_seen  = 1'b1;
                                n_st.reported         = 1'b1;
                                changed               = 1'b1;
                            end
                        end else if (i_cfg.repeat_enable && !i_cfg.long_press_enable) begin
                            if (hold_inc >= i_cfg.repeat_start_ticks) begin
                                n_st.repeat_count = RPT_ONE;
                                n_st.hold_count   = '0;
                            end
                        end
                    end
                end else if (~|win) begin
                    if (i_state.debounced) begin
                        // Release: a hidden short press becomes a one-read pulse.
                        n_st.debounced       = 1'b0;
                        n_st.long_press_seen = 1'b0;
                        changed              = 1'b1;
                        if (i_state.pulse_on_release) begin
                            n_st.pulse_on_release = 1'b0;
                            n_st.pulse_pending    = 1'b1;
                            n_st.reported         = 1'b1;
                        end else begin
                            n_st.reported = 1'b0;
                        end
                    end else if (i_state.reported && !i_state.pulse_pending) begin
                        // Key is up but still reported down after a repeat or pulse.
                        n_st.reported = 1'b0;
                        changed       = 1'b1;
                    end
                end else begin
                    // Mixed window: the key is bouncing.
                    n_st.hold_count   = '0;
                    n_st.repeat_count = '0;
                end
            end
            bdlp_pkg::FUNC_READ: begin
                n_st.pulse_pending = 1'b0;
            end
            bdlp_pkg::FUNC_READ_CLR: begin
                n_st.long_press_seen = 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign o_state            = n_st;
    assign o_result.changed   = changed;
    assign o_result.reported  = n_st.reported;
    assign o_result.long_hold = i_state.long_press_seen;

endmodule

// ===== tb/key_qualifier_checker.sv =====
// ----------------------------------------------------------------------------
// key_qualifier_checker
// Watches the item, result and configuration ports of the push-button
// qualifier. It keeps its own copy of the key state and settings, works out
// the result of every accepted item and compares each result transfer, field
// by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module key_qualifier_checker
    import bdlp_pkg::*;
#(
    parameter int unsigned STABLE_SAMPLES = STABLE_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic                  i_sample,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_changed,
    input  logic                  i_reported,
    input  logic                  i_long_hold,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // The newest STABLE_SAMPLES bits of the history form the window.
    localparam logic [HIST_W-1:0] WINDOW_MASK = HIST_W'(((1 << STABLE_SAMPLES) - 1) & 8'hFF);

    // Settings as last written.
    logic              lp_enable;
    logic              rpt_enable;
    logic [HOLD_W-1:0] lp_ticks;
    logic [HOLD_W-1:0] rpt_start;
    logic [RPT_W-1:0]  rpt_half;

    // Key state.
    logic [HIST_W-1:0] history;
    logic              debounced;
    logic              shown_level;
    logic [HOLD_W-1:0] hold_ticks;
    logic [RPT_W-1:0]  repeat_ticks;
    logic              release_armed;
    logic              pulse_waiting;
    logic              long_flag;

    t_result key_results_due[$];
    int      mismatches;

    // Return to the state and settings held after reset.
    task automatic clear_key_state();
        lp_enable     = 1'b0;
        rpt_enable    = 1'b0;
        lp_ticks      = LONG_PRESS_TICKS_RST;
        rpt_start     = REPEAT_START_TICKS_RST;
        rpt_half      = REPEAT_HALF_PERIOD_RST;
        history       = '0;
        debounced     = 1'b0;
        shown_level   = 1'b0;
        hold_ticks    = '0;
        repeat_ticks  = '0;
        release_armed = 1'b0;
        pulse_waiting = 1'b0;
        long_flag     = 1'b0;
    endtask

    // Shift one raw sample in and update the key state; returns the change flag.
    function automatic logic tick_key(logic s);
        logic [HIST_W-1:0] win;
        history = {history[HIST_W-2:0], s};
        win     = history & WINDOW_MASK;
        if (win == WINDOW_MASK) begin
            // A fresh press is either shown at once or hidden until release.
            if (!debounced) begin
                debounced = 1'b1;
                if (lp_enable) begin
                    release_armed = 1'b1;
                    shown_level   = 1'b0;
                    return 1'b0;
                end
                shown_level = 1'b1;
                return 1'b1;
            end
            // Auto-repeat toggles the shown level when its count runs out.
            if (repeat_ticks != '0 && !lp_enable) begin
                repeat_ticks = repeat_ticks - RPT_W'(1);
                if (repeat_ticks == '0) begin
                    shown_level  = ~shown_level;
                    repeat_ticks = rpt_half;
                    return 1'b1;
                end
            end
            if (hold_ticks != '1) begin
                hold_ticks = hold_ticks + HOLD_W'(1);
            end
            if (release_armed) begin
                if (hold_ticks >= lp_ticks) begin
                    release_armed = 1'b0;
                    long_flag     = 1'b1;
                    shown_level   = 1'b1;
                    return 1'b1;
                end
            end else if (rpt_enable && !lp_enable) begin
                if (hold_ticks >= rpt_start) begin
                    repeat_ticks = RPT_W'(1);
                    hold_ticks   = '0;
                end
            end
        end else if (win == '0) begin
            // Release: a hidden short press turns into a pulse held until read.
            if (debounced) begin
                debounced = 1'b0;
                long_flag = 1'b0;
                if (release_armed) begin
                    release_armed = 1'b0;
                    pulse_waiting = 1'b1;
                    shown_level   = 1'b1;
                    return 1'b1;
                end
                shown_level = 1'b0;
                return 1'b1;
            end
            if (shown_level && !pulse_waiting) begin
                shown_level = 1'b0;
                return 1'b1;
            end
        end else begin
            // A mixed window restarts the hold and repeat timing.
            hold_ticks   = '0;
            repeat_ticks = '0;
        end
        return 1'b0;
    endfunction

    // Result of one item, with the state updated accordingly.
    function automatic t_result qualify_key_item(logic [FUNC_W-1:0] f, logic s);
        t_result r;
        r.changed   = 1'b0;
        r.long_hold = long_flag;
        case (f)
            FUNC_TICK:     r.changed = tick_key(s);
            FUNC_READ:     pulse_waiting = 1'b0;
            FUNC_READ_CLR: long_flag = 1'b0;
            default: ;
        endcase
        r.reported = shown_level;
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
        end
    endtask

    // Settings first, then the result transfer, then the new item, all as seen
    // just before this edge.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_key_state();
            key_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LONG_PRESS_ENABLE:  lp_enable  = i_cfg_data[0];
                    CFG_REPEAT_ENABLE:      rpt_enable = i_cfg_data[0];
                    CFG_LONG_PRESS_TICKS:   lp_ticks   = i_cfg_data;
                    CFG_REPEAT_START_TICKS: rpt_start  = i_cfg_data;
                    CFG_REPEAT_HALF_PERIOD: rpt_half   = i_cfg_data[RPT_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (key_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none due, expected none, actual %0b%0b%0b",
                             $time, i_changed, i_reported, i_long_hold);
                end else begin
                    want = key_results_due.pop_front();
                    check_field("changed", want.changed, i_changed);
                    check_field("reported", want.reported, i_reported);
                    check_field("long_hold", want.long_hold, i_long_hold);
                end
            end
            if (i_in_valid && i_in_ready) begin
                key_results_due.push_back(qualify_key_item(i_func, i_sample));
            end
        end
        o_outstanding <= key_results_due.size();
        o_fail_count  <= mismatches;
    end

    initial begin
        mismatches    = 0;
        o_fail_count  = 0;
        o_outstanding = 0;
        clear_key_state();
    end

endmodule

// ===== tb/button_debounce_long_press_repeat_unit_tb.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_unit_tb
// Drives key gestures, reads and noise into the push-button qualifier under
// several settings and idling patterns, including one long hold, and
// reports the verdict of the checker that sits beside it.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat_unit_tb;

    import bdlp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STABLE_SAMPLES = STABLE_SAMPLES_DEF;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned LONG_STALL     = 400;
    // Function code that the block does not define.
    localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic [FUNC_W-1:0]     func_code   = '0;
    logic                  sample      = 1'b0;
    logic                  out_ready   = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  changed;
    logic                  reported;
    logic                  long_hold;
    int                    fail_count;
    int                    results_outstanding;

    int          send_idle_pct   = 0;
    int          recv_stall_pct  = 0;
    bit          long_stall_req  = 1'b0;
    int          items_sent      = 0;
    int unsigned cycle_count     = 0;

    button_debounce_long_press_repeat_unit #(
        .STABLE_SAMPLES (STABLE_SAMPLES)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_func       (func_code),
        .i_sample     (sample),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_changed    (changed),
        .o_reported   (reported),
        .o_long_hold  (long_hold),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    key_qualifier_checker #(
        .STABLE_SAMPLES (STABLE_SAMPLES)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_func        (func_code),
        .i_sample      (sample),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_changed     (changed),
        .i_reported    (reported),
        .i_long_hold   (long_hold),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (results_outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, or one long hold-off on request.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left     = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one item, after an optional gap, and wait for its transfer.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        func_code <= f;
        sample    <= s;
        items_sent++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // One read of either kind, now and then an undefined code.
    task automatic send_read();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5) begin
            send_item(FUNC_READ, $urandom_range(1));
        end else if (pick < 9) begin
            send_item(FUNC_READ_CLR, $urandom_range(1));
        end else begin
            send_item(FUNC_RESERVED, $urandom_range(1));
        end
    endtask

    task automatic bounce_key();
        repeat ($urandom_range(3)) send_item(FUNC_TICK, $urandom_range(1));
    endtask

    // Press, hold and release with contact bounce and reads mixed in.
    task automatic key_gesture(input int unsigned hold_max);
        bounce_key();
        repeat ($urandom_range(hold_max, 1)) begin
            if ($urandom_range(99) < 8) send_read();
            send_item(FUNC_TICK, 1'b1);
        end
        bounce_key();
        repeat ($urandom_range(10, 1)) begin
            if ($urandom_range(99) < 8) send_read();
            send_item(FUNC_TICK, 1'b0);
        end
        if ($urandom_range(1)) send_read();
    endtask

    task automatic run_gestures(input int unsigned n_items, input int unsigned hold_max);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(6, 1)) send_item($urandom_range(3), $urandom_range(1));
            end else begin
                key_gesture(hold_max);
            end
        end
    endtask

    // Wait until every result due has been transferred.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_outstanding != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
    endtask

    // Write every register once the block is idle.
    task automatic configure(input logic lpe, input logic rpe, input logic [HOLD_W-1:0] lpt,
                             input logic [HOLD_W-1:0] rst_ticks, input logic [RPT_W-1:0] rhp);
        drain_results();
        write_reg(CFG_LONG_PRESS_ENABLE, {15'd0, lpe});
        write_reg(CFG_REPEAT_ENABLE, {15'd0, rpe});
        write_reg(CFG_LONG_PRESS_TICKS, lpt);
        write_reg(CFG_REPEAT_START_TICKS, rst_ticks);
        write_reg(CFG_REPEAT_HALF_PERIOD, {1'b0, rhp});
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads and the undefined code at reset, an unstable window,
        // then a clean press and release with the reset settings.
        send_item(FUNC_READ, 1'b0);
        send_item(FUNC_READ_CLR, 1'b1);
        send_item(FUNC_RESERVED, 1'b1);
        send_item(FUNC_RESERVED, 1'b0);
        send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_TICK, 1'b1);
        repeat (5) send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_READ, 1'b1);
        repeat (5) send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_READ, 1'b0);
        send_item(FUNC_READ_CLR, 1'b0);

        // Short repeat timing, no idling; the result side holds off for a long
        // stretch at the start so the block fills and stalls its input.
        configure(1'b0, 1'b1, 16'd5, 16'd3, 15'd2);
        set_idling(0, 0);
        long_stall_req = 1'b1;
        run_gestures(200, 25);

        // Long-press mode with repeat requested, sender idling.
        configure(1'b1, 1'b1, 16'd6, 16'd65535, 15'd1);
        set_idling(55, 0);
        run_gestures(200, 14);

        // Zero delays and zero repeat period, receiver stalling.
        configure(1'b0, 1'b1, 16'd0, 16'd0, 15'd0);
        set_idling(0, 55);
        run_gestures(200, 12);

        // Immediate long press and the longest repeat period, both idling.
        configure(1'b1, 1'b0, 16'd0, 16'd1, 15'd32767);
        set_idling(8, 8);
        run_gestures(200, 8);

        // Random small settings, no idling.
        configure($urandom_range(1), $urandom_range(1), $urandom_range(20),
                  $urandom_range(20), $urandom_range(6));
        set_idling(0, 0);
        run_gestures(200, 30);

        // Long hold: the long-press delay is reached, then repeat is switched
        // on mid-hold and starts from the hold count built up so far.
        configure(1'b0, 1'b0, 16'd0, 16'd0, 15'd0);
        repeat (6) send_item(FUNC_TICK, 1'b0);
        configure(1'b1, 1'b0, 16'd150, 16'd65535, 15'd32767);
        repeat (160) send_item(FUNC_TICK, 1'b1);
        send_item(FUNC_READ_CLR, 1'b1);
        configure(1'b0, 1'b1, 16'd65535, 16'd100, 15'd3);
        repeat (20) send_item(FUNC_TICK, 1'b1);
        repeat (6) send_item(FUNC_TICK, 1'b0);
        send_item(FUNC_READ, 1'b0);

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && results_outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/bdlp_pkg.sv
src/bdlp_step.sv
src/button_debounce_long_press_repeat_unit.sv
tb/key_qualifier_checker.sv
tb/button_debounce_long_press_repeat_unit_tb.sv
